// File: hw/rtl/cdl_pkg.sv
// shared constants and opcodes for the circular doubly linked list manager
`default_nettype none

package cdl_pkg;

    localparam int NODE_COUNT_DEF = 256;
    localparam int FIELD_W        = 8;
    localparam int OP_W           = 3;

    localparam logic [OP_W-1:0] OP_DETACH     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd4;

endpackage

`default_nettype wire

// File: hw/rtl/cdl_if.sv
// request and response channel interfaces
`default_nettype none

interface cdl_req_if
    import cdl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [FIELD_W-1:0] first_node;
    logic [FIELD_W-1:0] second_node;

    modport source (output valid, output opcode, output first_node, output second_node,
                    input ready);
    modport sink   (input valid, input opcode, input first_node, input second_node,
                    output ready);
endinterface

interface cdl_rsp_if
    import cdl_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] popped_node;
    logic               removed;

    modport source (output valid, output popped_node, output removed, input ready);
    modport sink   (input valid, input popped_node, input removed, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cdl_wrap.sv
// shared index wrap unit: registers an 8-bit node field and reduces it modulo the pool size
`default_nettype none

module cdl_wrap
    import cdl_pkg::*;
#(
    parameter  int NODE_COUNT = NODE_COUNT_DEF,
    localparam int IW         = $clog2(NODE_COUNT)
) (
    input  wire logic               i_clk,
    input  wire logic [FIELD_W-1:0] i_value,
    output logic      [IW-1:0]      o_node
);

    logic [FIELD_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        r_value <= i_value;
    end

    generate
        if (NODE_COUNT >= 256) begin : g_wide
            // every 8-bit value is already a valid index
            assign o_node = IW'(r_value);
        end else if ((NODE_COUNT & (NODE_COUNT - 1)) == 0) begin : g_pow2
            assign o_node = r_value[IW-1:0];
        end else begin : g_recip
            // quotient by reciprocal multiply, exact for 8-bit values
            localparam int QSH   = 16;
            localparam int RECIP = ((1 << QSH) + NODE_COUNT - 1) / NODE_COUNT;
            localparam int RW    = $clog2(RECIP + 1);
            localparam int PW    = FIELD_W + RW;

            logic [PW-1:0]      prod;
            logic [FIELD_W-1:0] r_quot;
            logic [2*FIELD_W-1:0] back;
            logic [FIELD_W-1:0] rem;

            assign prod = PW'(i_value) * PW'(RECIP);

            always_ff @(posedge i_clk) begin
                r_quot <= FIELD_W'(prod >> QSH);
            end

            assign back   = (2*FIELD_W)'(r_quot) * (2*FIELD_W)'(NODE_COUNT);
            assign rem    = r_value - back[FIELD_W-1:0];
            assign o_node = rem[IW-1:0];
        end
    endgenerate

endmodule

`default_nettype wire

// File: hw/rtl/cdl_mem.sv
// link memory: one write port and one registered read port
`default_nettype none

module cdl_mem
    import cdl_pkg::*;
#(
    parameter  int NODE_COUNT = NODE_COUNT_DEF,
    localparam int IW         = $clog2(NODE_COUNT)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire logic [IW-1:0] i_wdata,
    input  wire logic [IW-1:0] i_raddr,
    output logic      [IW-1:0] o_rdata
);

    logic [IW-1:0] mem [NODE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/circular_doubly_linked_list_manager.sv
// top level: sequencer over the link memories and the shared index wrap unit
//
//  channel   dir   handshake            payload
//  i_req     in    valid / ready        opcode, first_node, second_node
//  o_rsp     out   valid / ready        popped_node, removed
//
//  steps: detach, self insert, empty pop and unused opcodes go idle, wrap, fetch,
//  exec, done; an insert adds a second write step and a removing pop an unlink step,
//  set by one read and one write port per link memory and the single shared wrap unit
//  reset: synchronous, active low; then a clearing pass over all NODE_COUNT nodes, ready low
//  stalls: a new beat is accepted while a result still waits in the output register
//  the block only waits in its final step while that register is full
`default_nettype none

module circular_doubly_linked_list_manager
    import cdl_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cdl_req_if.sink   i_req,
    cdl_rsp_if.source o_rsp
);

    localparam int IW = $clog2(NODE_COUNT);

    // sequencer states
    localparam logic [2:0] S_CLEAR  = 3'd0;  // reset sweep of both link memories
    localparam logic [2:0] S_IDLE   = 3'd1;  // waiting for a request beat
    localparam logic [2:0] S_WRAP_B = 3'd2;  // first node leaves wrap unit, second enters
    localparam logic [2:0] S_FETCH  = 3'd3;  // read links of the operand node
    localparam logic [2:0] S_EXEC   = 3'd4;  // first write step, or find the pop victim
    localparam logic [2:0] S_WRITE2 = 3'd5;  // second write step of an insert
    localparam logic [2:0] S_UNLINK = 3'd6;  // unlink the popped node
    localparam logic [2:0] S_DONE   = 3'd7;  // hand result to output register

    logic [2:0]         r_state, n_state;
    logic [IW-1:0]      r_cnt, n_cnt;
    logic [OP_W-1:0]    r_op, n_op;
    logic [FIELD_W-1:0] r_sec, n_sec;
    logic [IW-1:0]      r_a, n_a;
    logic [IW-1:0]      r_b, n_b;
    logic [IW-1:0]      r_t, n_t;      // victim or saved neighbor
    logic [FIELD_W-1:0] r_res_node, n_res_node;
    logic               r_res_rm, n_res_rm;

    logic               r_out_valid;
    logic [FIELD_W-1:0] r_out_node;
    logic               r_out_rm;
    logic               out_load;

    // shared wrap unit
    logic [FIELD_W-1:0] wrap_in;
    logic [IW-1:0]      wrap_node;

    // link memory ports
    logic               nx_we, pv_we;
    logic [IW-1:0]      nx_waddr, nx_wdata, pv_waddr, pv_wdata;
    logic [IW-1:0]      rd_addr;
    logic [IW-1:0]      nx_rd, pv_rd;
    logic [IW-1:0]      victim;

    cdl_wrap #(.NODE_COUNT(NODE_COUNT)) u_wrap (
        .i_clk   (i_clk),
        .i_value (wrap_in),
        .o_node  (wrap_node)
    );

    cdl_mem #(.NODE_COUNT(NODE_COUNT)) u_next (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (rd_addr),
        .o_rdata (nx_rd)
    );

    cdl_mem #(.NODE_COUNT(NODE_COUNT)) u_prev (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (rd_addr),
        .o_rdata (pv_rd)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign victim      = (r_op == OP_POP_FRONT) ? nx_rd : pv_rd;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_op       = r_op;
        n_sec      = r_sec;
        n_a        = r_a;
        n_b        = r_b;
        n_t        = r_t;
        n_res_node = r_res_node;
        n_res_rm   = r_res_rm;
        wrap_in    = r_sec;
        rd_addr    = r_a;
        nx_we      = 1'b0;
        nx_waddr   = r_a;
        nx_wdata   = r_a;
        pv_we      = 1'b0;
        pv_waddr   = r_a;
        pv_wdata   = r_a;

        case (r_state)
            S_CLEAR: begin
                // every node links to itself
                nx_we    = 1'b1;
                nx_waddr = r_cnt;
                nx_wdata = r_cnt;
                pv_we    = 1'b1;
                pv_waddr = r_cnt;
                pv_wdata = r_cnt;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == IW'(NODE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                wrap_in = i_req.first_node;
                if (i_req.valid) begin
                    n_op    = i_req.opcode;
                    n_sec   = i_req.second_node;
                    n_state = S_WRAP_B;
                end
            end
            S_WRAP_B: begin
                n_a     = wrap_node;
                wrap_in = r_sec;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                n_b = wrap_node;
                // insert-after reads its anchor, all others read the first node
                rd_addr = (r_op == OP_INS_AFTER) ? wrap_node : r_a;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_res_node = '0;
                n_res_rm   = 1'b0;
                n_state    = S_DONE;
                case (r_op)
                    OP_DETACH: begin
                        nx_we    = 1'b1;
                        nx_waddr = pv_rd;
                        nx_wdata = nx_rd;
                        pv_we    = 1'b1;
                        pv_waddr = nx_rd;
                        pv_wdata = pv_rd;
                    end
                    OP_INS_BEFORE: begin
                        // anchor a, new node b: next[before] = b, prev[b] = before
                        if (r_a != r_b) begin
                            nx_we    = 1'b1;
                            nx_waddr = pv_rd;
                            nx_wdata = r_b;
                            pv_we    = 1'b1;
                            pv_waddr = r_b;
                            pv_wdata = pv_rd;
                            n_state  = S_WRITE2;
                        end
                    end
                    OP_INS_AFTER: begin
                        // new node a, anchor b: next[b] = a, prev[a] = b, keep old next
                        if (r_a != r_b) begin
                            nx_we    = 1'b1;
                            nx_waddr = r_b;
                            nx_wdata = r_a;
                            pv_we    = 1'b1;
                            pv_waddr = r_a;
                            pv_wdata = r_b;
                            n_t      = nx_rd;
                            n_state  = S_WRITE2;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        // head linking to itself means an empty list
                        if (victim != r_a) begin
                            rd_addr = victim;
                            n_t     = victim;
                            n_state = S_UNLINK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WRITE2: begin
                nx_we   = 1'b1;
                pv_we   = 1'b1;
                n_state = S_DONE;
                if (r_op == OP_INS_BEFORE) begin
                    nx_waddr = r_b;
                    nx_wdata = r_a;
                    pv_waddr = r_a;
                    pv_wdata = r_b;
                end else begin
                    nx_waddr = r_a;
                    nx_wdata = r_t;
                    pv_waddr = r_t;
                    pv_wdata = r_a;
                end
            end
            S_UNLINK: begin
                nx_we      = 1'b1;
                nx_waddr   = pv_rd;
                nx_wdata   = nx_rd;
                pv_we      = 1'b1;
                pv_waddr   = nx_rd;
                pv_wdata   = pv_rd;
                n_res_node = FIELD_W'(32'(r_t));
                n_res_rm   = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_sec      <= n_sec;
        r_a        <= n_a;
        r_b        <= n_b;
        r_t        <= n_t;
        r_res_node <= n_res_node;
        r_res_rm   <= n_res_rm;
        if (out_load) begin
            r_out_node <= r_res_node;
            r_out_rm   <= r_res_rm;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.popped_node = r_out_node;
    assign o_rsp.removed     = r_out_rm;

    // clearing sweep steps one node per cycle
    a_clear_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_cnt != IW'(NODE_COUNT - 1))
        |=> (r_state == S_CLEAR && r_cnt == IW'($past(r_cnt) + 1'b1)))
        else $error("clearing sweep skipped a node");

    // only a pop can report a removed node, and never its own head
    a_rm_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_res_rm)
        |-> ((r_op == OP_POP_FRONT || r_op == OP_POP_BACK) && r_t != r_a))
        else $error("removed flag outside a pop");

    // a result with nothing removed carries a zero node
    a_zero_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.removed) |-> (o_rsp.popped_node == '0))
        else $error("nonzero node without removal");

    // no request is taken before the clearing sweep ends
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !($past(i_req.valid) && $past(i_req.ready)))
        else $error("request accepted during clearing sweep");

endmodule

`default_nettype wire
